### rtl/double_ended_queue_with_search_top_macros.svh
// assertion macros for the deque with search
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

// condition that must never hold
`define DEQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define DEQ_ASSERT_IMP(lbl, cond, prop, msg)
`define DEQ_ASSERT_NXT(lbl, cond, prop, msg)
`define DEQ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/deq_pkg.sv
package deq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_FINISH
  } deq_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic dispatch;
    logic push;
    logic pop_rd;
    logic srch_rd;
    logic pop_cap;
    logic srch_hit;
    logic load_out;
  } deq_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       hit;
    logic       last;
    logic       out_free;
  } deq_stat_t;

endpackage

### rtl/double_ended_queue_with_search_top.sv
// Bounded double-ended queue of DEPTH words with a membership search.
// Input channel in_*: one word per command (push front, push back, pop front,
// pop back, search). Output channel out_*: one result word per command with
// status, popped word, found flag and occupancy after the command.
// Commands are taken one at a time; the controller walks each through a
// dispatch step and a finish step that loads the output register.
// Push, refused pop or push, empty search and unknown codes go straight from
// dispatch to finish; a pop adds a wait step for the registered memory read;
// a search compares one stored word per cycle through the single read port
// of the ring until a hit or until every stored word has been compared.
// A finished result waits in the output register while the next command is
// accepted; if out_tready stays low, the following result waits in the
// finish step and in_tready stays low until the register frees.
// Reset clears the front index, the count and all handshake state; the
// ring contents are not cleared and need no clearing pass.
module double_ended_queue_with_search_top #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[2:0], value[34:3], zero[39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], popped[33:2], found[34], occupancy[39:35]
);
  import deq_pkg::*;

  deq_ctrl_t   ctl;
  deq_stat_t   st;
  logic [1:0]  out_status;
  logic [31:0] out_popped;
  logic        out_found;
  logic [4:0]  out_occupancy;

  // controller
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .ctl       (ctl)
  );

  // datapath
  deq_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_tdata[2:0]),
    .in_value      (in_tdata[34:3]),
    .ctl           (ctl),
    .st            (st),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_found     (out_found),
    .out_occupancy (out_occupancy)
  );

  // result word packing
  assign out_tdata = {out_occupancy, out_found, out_popped, out_status};

`include "double_ended_queue_with_search_top_macros.svh"

  // checks
  `DEQ_ASSERT_NEVER(a_empty_full, st.empty && st.full, "queue both empty and full")
  `DEQ_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second word taken during a command")
  `DEQ_ASSERT_IMP(a_empty_no_word, out_tvalid && (out_status == STAT_EMPTY), (out_popped == '0) && !out_found, "refused pop carries data")
  `DEQ_ASSERT_IMP(a_full_no_found, out_tvalid && (out_status == STAT_FULL), !out_found && (out_popped == '0), "refused push carries data")

endmodule

### rtl/deq_ctrl.sv
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  deq_pkg::deq_stat_t st,
  output deq_pkg::deq_ctrl_t ctl
);
  import deq_pkg::*;

  deq_state_t state_r;
  deq_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (st.op)
          CMD_POP_FRONT, CMD_POP_BACK: begin
            state_nxt = st.empty ? ST_FINISH : ST_POP_WAIT;
          end
          CMD_SEARCH: begin
            state_nxt = st.empty ? ST_FINISH : ST_SEARCH;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_POP_WAIT: state_nxt = ST_FINISH;
      ST_SEARCH: begin
        if (st.hit || st.last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.latch = in_tvalid;
      end
      ST_DISPATCH: begin
        ctl.dispatch = 1'b1;
        unique case (st.op)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: ctl.push = !st.full;
          CMD_POP_FRONT, CMD_POP_BACK:   ctl.pop_rd = !st.empty;
          CMD_SEARCH:                    ctl.srch_rd = !st.empty;
          default: ;
        endcase
      end
      ST_POP_WAIT: ctl.pop_cap = 1'b1;
      ST_SEARCH: begin
        ctl.srch_hit = st.hit;
        ctl.srch_rd  = !st.hit && !st.last;
      end
      ST_FINISH: ctl.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/deq_dp.sv
module deq_dp #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_command,
  input  logic [31:0]        in_value,
  input  deq_pkg::deq_ctrl_t ctl,
  output deq_pkg::deq_stat_t st,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_popped,
  output logic               out_found,
  output logic [4:0]         out_occupancy
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (WIDTH < 32) ? WIDTH : 32;

  logic [WIDTH-1:0] ring_mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic [AW-1:0]    front_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [2:0]       op_r;
  logic [31:0]      key_r;
  logic [1:0]       res_status_r;
  logic [31:0]      res_popped_r;
  logic             res_found_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_popped_r;
  logic             out_found_r;
  logic [4:0]       out_occ_r;

  logic             is_push;
  logic             is_pop;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    front_inc;
  logic [CW-1:0]    count_dec;

  // ring position of an offset from the front
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                             input logic [AW-1:0] offset);
    logic [AW:0] sum;
    sum = (AW+1)'(front) + (AW+1)'(offset);
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign is_push   = (op_r == CMD_PUSH_FRONT) || (op_r == CMD_PUSH_BACK);
  assign is_pop    = (op_r == CMD_POP_FRONT) || (op_r == CMD_POP_BACK);
  assign count_dec = count_r - CW'(1);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = ring_pos(front_r, AW'(1));

  // status to controller
  assign st.op       = op_r;
  assign st.empty    = (count_r == '0);
  assign st.full     = (count_r == CW'(DEPTH));
  assign st.hit      = (rd_data_r[WW-1:0] == key_r[WW-1:0]);
  assign st.last     = (idx_r == count_r);
  assign st.out_free = !out_valid_r || out_tready;

  // write and read addresses
  assign wr_en   = ctl.push;
  assign wr_addr = (op_r == CMD_PUSH_FRONT) ? front_dec
                                            : ring_pos(front_r, count_r[AW-1:0]);
  assign rd_en   = ctl.pop_rd || ctl.srch_rd;
  always_comb begin
    if (ctl.srch_rd) begin
      rd_addr = ring_pos(front_r, idx_r[AW-1:0]);
    end else if (op_r == CMD_POP_FRONT) begin
      rd_addr = front_r;
    end else begin
      rd_addr = ring_pos(front_r, count_dec[AW-1:0]);
    end
  end

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem_r[wr_addr] <= WIDTH'(key_r[WW-1:0]);
    if (rd_en) rd_data_r <= ring_mem_r[rd_addr];
  end

  // front index and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (ctl.push) begin
      count_r <= count_r + CW'(1);
      if (op_r == CMD_PUSH_FRONT) front_r <= front_dec;
    end else if (ctl.pop_rd) begin
      count_r <= count_dec;
      if (op_r == CMD_POP_FRONT) front_r <= front_inc;
    end
  end

  // latched word and search cursor
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_r  <= in_command;
      key_r <= in_value;
      idx_r <= '0;
    end else if (ctl.srch_rd) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (ctl.dispatch) begin
      res_popped_r <= '0;
      res_found_r  <= 1'b0;
      if (is_pop && st.empty) begin
        res_status_r <= STAT_EMPTY;
      end else if (is_push && st.full) begin
        res_status_r <= STAT_FULL;
      end else begin
        res_status_r <= STAT_OK;
      end
    end
    if (ctl.pop_cap) res_popped_r <= 32'(rd_data_r[WW-1:0]);
    if (ctl.srch_hit) res_found_r <= 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status_r <= res_status_r;
      out_popped_r <= res_popped_r;
      out_found_r  <= res_found_r;
      out_occ_r    <= 5'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_popped    = out_popped_r;
  assign out_found     = out_found_r;
  assign out_occupancy = out_occ_r;

endmodule

### dv/deq_result_checker.sv
module deq_result_checker #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // command[2:0], value[34:3], zero[39:35]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // status[1:0], popped[33:2], found[34], occupancy[39:35]
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam logic [31:0] WORD_MASK = (WIDTH >= 32) ? '1 : 32'((64'd1 << WIDTH) - 1);

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]  occupancy;
    logic        found;
    logic [31:0] popped;
    logic [1:0]  status;
  } deq_result_t;

  // shadow deque
  logic [31:0] shadow_ring [DEPTH];
  int          shadow_front;
  int          shadow_held;

  deq_result_t results_due [$];
  deq_result_t got;
  deq_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // apply one command to the shadow deque and return its result
  function automatic deq_result_t apply_command(logic [2:0] cmd, logic [31:0] value);
    deq_result_t r;
    logic [31:0] word;
    r        = '0;
    r.status = STAT_OK;
    word     = value & WORD_MASK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = word;
          shadow_held++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_held) % DEPTH] = word;
          shadow_held++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped     = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_held--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_ring[(shadow_front + shadow_held - 1) % DEPTH];
          shadow_held--;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_held; i++) begin
          if ((shadow_ring[(shadow_front + i) % DEPTH] & WORD_MASK) == word) r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = 5'(shadow_held);
    return r;
  endfunction

  // results are checked before the word accepted on the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_front = 0;
      shadow_held  = 0;
      results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", out_tdata));
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.popped != want.popped)
            report_mismatch($sformatf("popped %h, expected %h", got.popped, want.popped));
          if (got.found != want.found)
            report_mismatch($sformatf("found %0d, expected %0d", got.found, want.found));
          if (got.occupancy != want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      got.occupancy, want.occupancy));
        end
      end
      if (in_tvalid && in_tready) results_due.push_back(apply_command(in_tdata[2:0],
                                                                      in_tdata[34:3]));
    end
    pending <= results_due.size();
  end

endmodule

### dv/double_ended_queue_with_search_top_tb.sv
module double_ended_queue_with_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // codes the block treats as no operation
  localparam logic [2:0] CMD_NOP_FIRST = 3'd5;
  localparam logic [2:0] CMD_NOP_LAST  = 3'd7;

  localparam int RANDOM_WORDS = 650;
  localparam int PHASE_LEN    = 40;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;
  int          burst_left;
  logic [31:0] value_pool [8];

  always #1 clk = ~clk;

  double_ended_queue_with_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  deq_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver backpressure, switching pattern at random intervals
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
      default:    out_tready <= ~out_tready;
    endcase
  end

  // hold one word on the input until it is taken, then maybe idle between bursts
  task automatic send_word(logic [2:0] cmd, logic [31:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, value, cmd};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // mostly reuse recent words so searches hit
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    cmd_mix_t    mix;
    int          roll;
    int          push_pct;
    int          pop_pct;
    int          search_pct;
    logic [2:0]  cmd;
    logic [31:0] value;

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
    burst_left = $urandom_range(1, 20);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: refused pops, empty search, unused codes
    send_word(CMD_POP_FRONT, '1);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_SEARCH, '0);
    for (int c = CMD_NOP_FIRST; c <= CMD_NOP_LAST; c++) send_word(3'(c), $urandom);

    // extreme words at both ends, hits and a miss, then drain past empty
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_PUSH_BACK, '1);
    send_word(CMD_PUSH_FRONT, 32'h8000_0001);
    send_word(CMD_SEARCH, '1);
    send_word(CMD_SEARCH, '0);
    send_word(CMD_SEARCH, 32'h7fff_fffe);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_POP_FRONT, '1);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '1);

    // random phases that lean towards full, towards empty, or neither
    mix        = MIX_FILL;
    push_pct   = 0;
    pop_pct    = 0;
    search_pct = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n < 2 * PHASE_LEN) mix = cmd_mix_t'(n / PHASE_LEN);
        else mix = cmd_mix_t'($urandom_range(0, 2));
        case (mix)
          MIX_FILL: begin
            push_pct = 65; pop_pct = 15; search_pct = 15;
          end
          MIX_DRAIN: begin
            push_pct = 15; pop_pct = 65; search_pct = 15;
          end
          default: begin
            push_pct = 40; pop_pct = 35; search_pct = 20;
          end
        endcase
      end

      // let the block run dry once midway
      if (n == RANDOM_WORDS / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end

      roll  = $urandom_range(0, 99);
      value = pick_value();
      if (roll < push_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if ($urandom_range(0, 1)) value_pool[$urandom_range(0, 7)] = value;
      end else if (roll < push_pct + pop_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end else if (roll < push_pct + pop_pct + search_pct) begin
        cmd = CMD_SEARCH;
      end else begin
        cmd = 3'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
      end
      send_word(cmd, value);
    end

    // drain and settle
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
